/* hw/rtl/lzw_pkg.sv */
`default_nettype none
package lzw_pkg;

   localparam int CODE_BITS_DEF  = 12;
   localparam int TABLE_SIZE_DEF = 5021;
   localparam int EPOCH_BITS     = 4;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_REDUCE,
      ST_STEP,
      ST_READ,
      ST_CMP,
      ST_LOAD_PRE,
      ST_DRAIN_PRE,
      ST_LOAD_FIN,
      ST_DRAIN_FIN,
      ST_LOAD_END,
      ST_DRAIN_END,
      ST_LOAD_ZERO,
      ST_DRAIN_ZERO,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      CS_PREFIX,
      CS_END,
      CS_ZERO
   } code_sel_type;

   typedef struct packed {
      logic         load_in;
      logic         open_stream;
      logic         start_hash;
      logic         reduce;
      logic         set_step;
      logic         mem_read;
      logic         advance;
      logic         take_hit;
      logic         insert;
      logic         load_code;
      code_sel_type code_sel;
      logic         set_prefix_byte;
      logic         drain;
      logic         mark_last;
      logic         clear_stream;
      logic         epoch_next;
      logic         clr_write;
   } cmd_type;

   typedef struct packed {
      logic idx_big;
      logic free;
      logic hit;
      logic tries_done;
      logic can_add;
      logic cnt_ge8;
      logic out_free;
      logic clr_done;
      logic stream_open;
      logic last;
      logic epoch_max;
   } status_type;

endpackage
`default_nettype wire

/* hw/rtl/lzw_ctrl.sv */
`default_nettype none
module lzw_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   input  wire lzw_pkg::status_type status,
   output lzw_pkg::cmd_type         cmd
);

   lzw_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lzw_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != lzw_pkg::ST_IDLE);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         lzw_pkg::ST_CLEAR: begin
            if (status.clr_done) state_in = lzw_pkg::ST_IDLE;
         end
         lzw_pkg::ST_IDLE: begin
            if (req_valid) state_in = lzw_pkg::ST_START;
         end
         lzw_pkg::ST_START: begin
            if (!status.stream_open) begin
               state_in = status.last ? lzw_pkg::ST_LOAD_FIN : lzw_pkg::ST_IDLE;
            end else begin
               state_in = lzw_pkg::ST_REDUCE;
            end
         end
         lzw_pkg::ST_REDUCE: begin
            if (!status.idx_big) state_in = lzw_pkg::ST_STEP;
         end
         lzw_pkg::ST_STEP: state_in = lzw_pkg::ST_READ;
         lzw_pkg::ST_READ: state_in = lzw_pkg::ST_CMP;
         lzw_pkg::ST_CMP: begin
            if (status.hit) begin
               state_in = status.last ? lzw_pkg::ST_LOAD_FIN : lzw_pkg::ST_IDLE;
            end else if (status.free || status.tries_done) begin
               state_in = lzw_pkg::ST_LOAD_PRE;
            end else begin
               state_in = lzw_pkg::ST_READ;
            end
         end
         lzw_pkg::ST_LOAD_PRE: state_in = lzw_pkg::ST_DRAIN_PRE;
         lzw_pkg::ST_DRAIN_PRE: begin
            if (!status.cnt_ge8) begin
               state_in = status.last ? lzw_pkg::ST_LOAD_FIN : lzw_pkg::ST_IDLE;
            end
         end
         lzw_pkg::ST_LOAD_FIN: state_in = lzw_pkg::ST_DRAIN_FIN;
         lzw_pkg::ST_DRAIN_FIN: begin
            if (!status.cnt_ge8) state_in = lzw_pkg::ST_LOAD_END;
         end
         lzw_pkg::ST_LOAD_END: state_in = lzw_pkg::ST_DRAIN_END;
         lzw_pkg::ST_DRAIN_END: begin
            if (!status.cnt_ge8) state_in = lzw_pkg::ST_LOAD_ZERO;
         end
         lzw_pkg::ST_LOAD_ZERO: state_in = lzw_pkg::ST_DRAIN_ZERO;
         lzw_pkg::ST_DRAIN_ZERO: begin
            if (!status.cnt_ge8) state_in = lzw_pkg::ST_FINISH;
         end
         lzw_pkg::ST_FINISH: begin
            state_in = status.epoch_max ? lzw_pkg::ST_CLEAR : lzw_pkg::ST_IDLE;
         end
         default: state_in = lzw_pkg::ST_CLEAR;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.code_sel = lzw_pkg::CS_PREFIX;
      case (state_ff)
         lzw_pkg::ST_CLEAR: cmd.clr_write = 1'b1;
         lzw_pkg::ST_IDLE: cmd.load_in = req_valid;
         lzw_pkg::ST_START: begin
            cmd.open_stream = !status.stream_open;
            cmd.start_hash  = status.stream_open;
         end
         lzw_pkg::ST_REDUCE: cmd.reduce = status.idx_big;
         lzw_pkg::ST_STEP: cmd.set_step = 1'b1;
         lzw_pkg::ST_READ: cmd.mem_read = 1'b1;
         lzw_pkg::ST_CMP: begin
            cmd.take_hit = status.hit;
            cmd.insert   = !status.hit && status.free && status.can_add;
            cmd.advance  = !status.hit && !status.free && !status.tries_done;
         end
         lzw_pkg::ST_LOAD_PRE: begin
            cmd.load_code       = 1'b1;
            cmd.code_sel        = lzw_pkg::CS_PREFIX;
            cmd.set_prefix_byte = 1'b1;
         end
         lzw_pkg::ST_LOAD_FIN: begin
            cmd.load_code = 1'b1;
            cmd.code_sel  = lzw_pkg::CS_PREFIX;
         end
         lzw_pkg::ST_LOAD_END: begin
            cmd.load_code = 1'b1;
            cmd.code_sel  = lzw_pkg::CS_END;
         end
         lzw_pkg::ST_LOAD_ZERO: begin
            cmd.load_code = 1'b1;
            cmd.code_sel  = lzw_pkg::CS_ZERO;
         end
         lzw_pkg::ST_DRAIN_PRE, lzw_pkg::ST_DRAIN_FIN, lzw_pkg::ST_DRAIN_END: begin
            cmd.drain = status.cnt_ge8 && status.out_free;
         end
         lzw_pkg::ST_DRAIN_ZERO: begin
            cmd.drain     = status.cnt_ge8 && status.out_free;
            cmd.mark_last = 1'b1;
         end
         lzw_pkg::ST_FINISH: begin
            cmd.clear_stream = 1'b1;
            cmd.epoch_next   = 1'b1;
         end
         default: cmd = '0;
      endcase
   end

endmodule
`default_nettype wire

/* hw/rtl/lzw_datapath.sv */
`default_nettype none
module lzw_datapath #(
   parameter int CODE_BITS  = lzw_pkg::CODE_BITS_DEF,
   parameter int TABLE_SIZE = lzw_pkg::TABLE_SIZE_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [7:0]       req_data_byte,
   input  wire logic             req_last_byte,
   input  wire lzw_pkg::cmd_type cmd,
   output lzw_pkg::status_type   status,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output logic [7:0]            rsp_out_byte,
   output logic                  rsp_out_last
);

   localparam int AW = $clog2(TABLE_SIZE);
   localparam int IW = (CODE_BITS > AW) ? CODE_BITS : AW;
   localparam int TW = $clog2(TABLE_SIZE + 1);
   localparam int PW = CODE_BITS + 8;
   localparam int CW = $clog2(PW);
   localparam int EW = lzw_pkg::EPOCH_BITS;
   localparam int DW = EW + 2 * CODE_BITS + 8;
   localparam logic [IW-1:0] TS_I = IW'(TABLE_SIZE);
   localparam logic [CODE_BITS:0] LAST_ADD = (CODE_BITS + 1)'((1 << CODE_BITS) - 2);

   logic [DW-1:0] mem [TABLE_SIZE];
   logic [DW-1:0] rd_ff;

   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic [CODE_BITS-1:0] prefix_ff, prefix_in;
   logic                 open_ff, open_in;
   logic [CODE_BITS:0]   nfc_ff, nfc_in;
   logic [PW-1:0]        pack_ff, pack_in;
   logic [CW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [IW-1:0]        step_ff, step_in;
   logic [TW-1:0]        tries_ff, tries_in;
   logic [EW-1:0]        epoch_ff, epoch_in;
   logic [AW-1:0]        clr_ff, clr_in;
   logic                 ov_ff, ov_in;
   logic [7:0]           ob_ff, ob_in;
   logic                 ol_ff, ol_in;

   logic [EW-1:0]        rd_epoch;
   logic [CODE_BITS-1:0] rd_code, rd_prefix;
   logic [7:0]           rd_char;
   logic [CODE_BITS-1:0] code_mux;
   logic [CW-1:0]        sh;
   logic [IW:0]          wrap_sum;
   logic                 out_free;

   assign {rd_epoch, rd_code, rd_prefix, rd_char} = rd_ff;
   assign out_free = !ov_ff || !rsp_stall;
   assign sh       = cnt_ff - CW'(8);
   assign wrap_sum = {1'b0, idx_ff} + {1'b0, TS_I} - {1'b0, step_ff};

   always_ff @(posedge clock) begin
      if (cmd.clr_write) begin
         mem[clr_ff] <= '0;
      end else if (cmd.insert) begin
         mem[idx_ff[AW-1:0]] <= {epoch_ff, nfc_ff[CODE_BITS-1:0], prefix_ff, byte_ff};
      end
      if (cmd.mem_read) begin
         rd_ff <= mem[idx_ff[AW-1:0]];
      end
   end

   always_comb begin
      case (cmd.code_sel)
         lzw_pkg::CS_PREFIX: code_mux = prefix_ff;
         lzw_pkg::CS_END:    code_mux = '1;
         lzw_pkg::CS_ZERO:   code_mux = '0;
         default:            code_mux = '0;
      endcase
   end

   always_comb begin
      byte_in   = byte_ff;
      last_in   = last_ff;
      prefix_in = prefix_ff;
      open_in   = open_ff;
      nfc_in    = nfc_ff;
      pack_in   = pack_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      step_in   = step_ff;
      tries_in  = tries_ff;
      epoch_in  = epoch_ff;
      clr_in    = clr_ff;
      ov_in     = ov_ff && rsp_stall;
      ob_in     = ob_ff;
      ol_in     = ol_ff;

      if (cmd.load_in) begin
         byte_in = req_data_byte;
         last_in = req_last_byte;
      end
      if (cmd.open_stream) begin
         prefix_in = CODE_BITS'(byte_ff);
         open_in   = 1'b1;
      end
      if (cmd.start_hash) begin
         idx_in = IW'({byte_ff, {(CODE_BITS - 8){1'b0}}} ^ prefix_ff);
      end
      if (cmd.reduce) begin
         idx_in = idx_ff - TS_I;
      end
      if (cmd.set_step) begin
         step_in  = (idx_ff == '0) ? IW'(1) : TS_I - idx_ff;
         tries_in = '0;
      end
      if (cmd.advance) begin
         // step back, wrapping around the table
         idx_in   = (idx_ff >= step_ff) ? idx_ff - step_ff : wrap_sum[IW-1:0];
         tries_in = tries_ff + TW'(1);
      end
      if (cmd.take_hit) begin
         prefix_in = rd_code;
      end
      if (cmd.insert) begin
         nfc_in = nfc_ff + (CODE_BITS + 1)'(1);
      end
      if (cmd.load_code) begin
         pack_in = {pack_ff[7:0], code_mux};
         cnt_in  = cnt_ff + CW'(CODE_BITS);
      end
      if (cmd.set_prefix_byte) begin
         prefix_in = CODE_BITS'(byte_ff);
      end
      if (cmd.drain) begin
         ob_in   = 8'(pack_ff >> sh);
         pack_in = pack_ff & ~({PW{1'b1}} << sh);
         cnt_in  = sh;
         ov_in   = 1'b1;
         ol_in   = cmd.mark_last && (sh < CW'(8));
      end
      if (cmd.clear_stream) begin
         open_in   = 1'b0;
         prefix_in = '0;
         nfc_in    = (CODE_BITS + 1)'(256);
         pack_in   = '0;
         cnt_in    = '0;
      end
      if (cmd.epoch_next) begin
         epoch_in = (epoch_ff == '1) ? EW'(1) : epoch_ff + EW'(1);
      end
      if (cmd.clr_write) begin
         clr_in = (clr_ff == AW'(TABLE_SIZE - 1)) ? '0 : clr_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prefix_ff <= '0;
         open_ff   <= 1'b0;
         nfc_ff    <= (CODE_BITS + 1)'(256);
         pack_ff   <= '0;
         cnt_ff    <= '0;
         epoch_ff  <= EW'(1);
         clr_ff    <= '0;
         ov_ff     <= 1'b0;
      end else begin
         prefix_ff <= prefix_in;
         open_ff   <= open_in;
         nfc_ff    <= nfc_in;
         pack_ff   <= pack_in;
         cnt_ff    <= cnt_in;
         epoch_ff  <= epoch_in;
         clr_ff    <= clr_in;
         ov_ff     <= ov_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      idx_ff   <= idx_in;
      step_ff  <= step_in;
      tries_ff <= tries_in;
      ob_ff    <= ob_in;
      ol_ff    <= ol_in;
   end

   always_comb begin
      status.idx_big     = (idx_ff >= TS_I);
      status.free        = (rd_epoch != epoch_ff);
      status.hit         = (rd_epoch == epoch_ff) && (rd_prefix == prefix_ff)
                           && (rd_char == byte_ff);
      status.tries_done  = (tries_ff == TW'(TABLE_SIZE - 1));
      status.can_add     = (nfc_ff <= LAST_ADD);
      status.cnt_ge8     = (cnt_ff >= CW'(8));
      status.out_free    = out_free;
      status.clr_done    = (clr_ff == AW'(TABLE_SIZE - 1));
      status.stream_open = open_ff;
      status.last        = last_ff;
      status.epoch_max   = (epoch_ff == '1);
   end

   assign rsp_valid    = ov_ff;
   assign rsp_out_byte = ob_ff;
   assign rsp_out_last = ol_ff;

endmodule
`default_nettype wire

/* hw/rtl/lzw_compressor.sv */
`default_nettype none
// LZW compressor with fixed-width codes packed msb first into bytes. The first byte of a
// stream becomes its prefix. Every later byte is hashed and probed in the dictionary, one
// probe after another until a hit, a free entry or the last try. Each code emitted is
// drained as output bytes, and draining waits while rsp_stall holds. The single-port
// dictionary memory is read once per probe. After reset and after every 15th stream the
// dictionary is swept clean, and req_stall stays high throughout. The final code, the end
// code and a zero code close each stream; rsp_out_last marks its last byte.
module lzw_compressor #(
   parameter int CODE_BITS  = lzw_pkg::CODE_BITS_DEF,
   parameter int TABLE_SIZE = lzw_pkg::TABLE_SIZE_DEF
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_last
);

   lzw_pkg::cmd_type    cmd;
   lzw_pkg::status_type status;

   lzw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   lzw_datapath #(
      .CODE_BITS  (CODE_BITS),
      .TABLE_SIZE (TABLE_SIZE)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .cmd           (cmd),
      .status        (status),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_last  (rsp_out_last)
   );

endmodule
`default_nettype wire

/* hw/rtl/lzw_checker.sv */
`default_nettype none
module lzw_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       req_valid,
   input wire logic       req_stall,
   input wire logic       rsp_valid,
   input wire logic       rsp_stall,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_last
);

   // one byte at a time: input closes right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("input taken on consecutive cycles");

   // dictionary sweep after reset holds off input
   assert property (@(posedge clock) reset |=> req_stall)
      else $error("input open right after reset");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> ($stable(rsp_out_byte) && $stable(rsp_out_last)))
      else $error("stalled result changed");

endmodule

bind lzw_compressor lzw_checker u_lzw_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_byte (rsp_out_byte),
   .rsp_out_last (rsp_out_last)
);
`default_nettype wire
